### hw/rtl/bwlp_pkg.sv
// shared types and constants for the fourth-order lowpass iir block
// no dependencies; imported by every module of the block
package bwlp_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 29;
  localparam int COEF_W     = 32;
  localparam int HIST_W     = 48;
  localparam int HIST_DEPTH = 4;
  localparam int TAP_W      = HIST_W + 4;   // h0 + 4*h1 + 6*h2 + 4*h3
  localparam int RES_W      = TAP_W + 1;    // taps plus the new word
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_OLDEST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_NEWEST = 3'd4;

  typedef logic [COEF_W-1:0] coef_t;

  // gain and feedback coefficients, fb[0] acts on the oldest history word
  typedef struct packed {
    logic [GAIN_W-1:0]            gain;
    coef_t [HIST_DEPTH-1:0]       fb;
  } coefs_t;

  // stage 1 to stage 2 payload
  typedef struct packed {
    logic signed [HIST_W-1:0] w;
    logic signed [TAP_W-1:0]  taps;
  } mid_t;

endpackage

### hw/rtl/bwlp_cfg.sv
// configuration register file: gain and four feedback coefficients
// depends on bwlp_pkg
module bwlp_cfg
  import bwlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output coefs_t                coefs
);

  coefs_t coefs_next;

  // index decode, writes beyond the list are dropped
  always_comb begin
    coefs_next = coefs;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INPUT_GAIN:      coefs_next.gain  = cfg_data[GAIN_W-1:0];
        CFG_FEEDBACK_OLDEST: coefs_next.fb[0] = cfg_data[COEF_W-1:0];
        CFG_FEEDBACK_THIRD:  coefs_next.fb[1] = cfg_data[COEF_W-1:0];
        CFG_FEEDBACK_SECOND: coefs_next.fb[2] = cfg_data[COEF_W-1:0];
        CFG_FEEDBACK_NEWEST: coefs_next.fb[3] = cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
    end else begin
      coefs <= coefs_next;
    end
  end

endmodule

### hw/rtl/bwlp_feedback.sv
// recursive section: new history word from sample, gain and feedback taps,
// the four-word delay line, and the binomial tap sum of the old history
// depends on bwlp_pkg
module bwlp_feedback
  import bwlp_pkg::*;
#(
  parameter int COEF_FRAC_BITS  = 28,
  parameter int STATE_FRAC_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic signed [SAMPLE_W-1:0] x,
  input  coefs_t                     coefs,
  output mid_t                       mid
);

  localparam int GPROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int PHI_W   = COEF_W + SAMPLE_W;
  localparam int PLO_W   = COEF_W + 33;
  localparam int PROD_W  = COEF_W + HIST_W + 1;
  localparam int ACC_W   = PROD_W + 3;
  localparam int SHIFT_D = STATE_FRAC_BITS - COEF_FRAC_BITS;
  localparam int SHL     = (SHIFT_D > 0) ? SHIFT_D : 0;
  localparam int SHR     = (SHIFT_D < 0) ? -SHIFT_D : 0;

  logic signed [HIST_W-1:0]  hist [HIST_DEPTH];
  logic signed [GPROD_W-1:0] gain_prod;
  logic signed [ACC_W-1:0]   gain_ext;
  logic signed [PHI_W-1:0]   p_hi [HIST_DEPTH];
  logic signed [PLO_W-1:0]   p_lo [HIST_DEPTH];
  logic signed [PROD_W-1:0]  prod [HIST_DEPTH];
  logic signed [ACC_W-1:0]   acc;
  logic signed [HIST_W-1:0]  w_next;
  logic signed [TAP_W-1:0]   taps_next;

  // gain term aligned to the state fraction, floor when shifting right
  assign gain_prod = GPROD_W'(x) * GPROD_W'($signed({1'b0, coefs.gain}));
  assign gain_ext  = ACC_W'(gain_prod);

  // feedback products, each 32x48 split into a high and a low partial product
  always_comb begin
    acc = (gain_ext <<< SHL) >>> SHR;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      p_hi[i] = PHI_W'($signed(coefs.fb[i])) * PHI_W'($signed(hist[i][HIST_W-1:32]));
      p_lo[i] = PLO_W'($signed(coefs.fb[i])) * PLO_W'($signed({1'b0, hist[i][31:0]}));
      prod[i] = (PROD_W'(p_hi[i]) <<< 32) + PROD_W'(p_lo[i]);
      acc     = acc + ACC_W'(prod[i] >>> COEF_FRAC_BITS);
    end
  end

  // clamp to the history word range
  always_comb begin
    if (acc[ACC_W-1:HIST_W-1] == '0 || acc[ACC_W-1:HIST_W-1] == '1) begin
      w_next = acc[HIST_W-1:0];
    end else if (acc[ACC_W-1]) begin
      w_next = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      w_next = {1'b0, {(HIST_W-1){1'b1}}};
    end
  end

  // numerator taps 1 4 6 4 on the old history, the new word is added later
  assign taps_next = TAP_W'(hist[0])
                   + (TAP_W'(hist[1]) <<< 2)
                   + (TAP_W'(hist[2]) <<< 2) + (TAP_W'(hist[2]) <<< 1)
                   + (TAP_W'(hist[3]) <<< 2);

  // delay line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (load) begin
      for (int i = 0; i < HIST_DEPTH - 1; i++) begin
        hist[i] <= hist[i+1];
      end
      hist[HIST_DEPTH-1] <= w_next;
    end
  end

  // stage register toward the output section
  always_ff @(posedge clk) begin
    if (load) begin
      mid.w    <= w_next;
      mid.taps <= taps_next;
    end
  end

endmodule

### hw/rtl/bwlp_round.sv
// output section: final sum, round half to even, clamp to int16, result register
// depends on bwlp_pkg
module bwlp_round
  import bwlp_pkg::*;
#(
  parameter int STATE_FRAC_BITS = 24
) (
  input  logic                       clk,
  input  logic                       load,
  input  mid_t                       mid,
  output logic signed [SAMPLE_W-1:0] filtered
);

  localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(SAMPLE_MAX);
  localparam logic signed [RES_W-1:0] OUT_MIN = RES_W'(SAMPLE_MIN);

  logic signed [RES_W-1:0] res;
  logic signed [RES_W-1:0] q;
  logic signed [RES_W-1:0] q_rnd;
  logic                    round_up;
  logic signed [SAMPLE_W-1:0] sat;

  assign res = RES_W'(mid.w) + RES_W'(mid.taps);
  assign q   = res >>> STATE_FRAC_BITS;

  // above half rounds up, exactly half rounds to the even neighbor
  assign round_up = res[STATE_FRAC_BITS-1]
                  && ((|res[STATE_FRAC_BITS-2:0]) || q[0]);
  assign q_rnd    = q + RES_W'(round_up);

  always_comb begin
    if (q_rnd > OUT_MAX) begin
      sat = OUT_MAX[SAMPLE_W-1:0];
    end else if (q_rnd < OUT_MIN) begin
      sat = OUT_MIN[SAMPLE_W-1:0];
    end else begin
      sat = q_rnd[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      filtered <= sat;
    end
  end

endmodule

### hw/rtl/butterworth_lowpass_iir4.sv
// fourth-order lowpass iir, one int16 sample in, one int16 sample out.
// an accepted item passes the input register, then the mid and result registers.
// throughput: one item per cycle unless the output stalls; the feedback word closes within the mid stage.
// reset (rst, synchronous): history and coefficients cleared, pipeline emptied.
// depends on bwlp_pkg, bwlp_cfg, bwlp_feedback, bwlp_round
module butterworth_lowpass_iir4
  import bwlp_pkg::*;
#(
  parameter int COEF_FRAC_BITS  = 28,
  parameter int STATE_FRAC_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] filtered,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  coefs_t                     coefs;
  mid_t                       mid;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       v0;
  logic                       v1;
  logic                       adv0;
  logic                       adv1;
  logic                       adv2;
  logic                       load1;
  logic                       load2;

  assign cfg_ready = 1'b1;

  // stage can take an item when empty or when its item moves on
  assign adv2     = !out_valid || !out_stall;
  assign adv1     = !v1 || adv2;
  assign adv0     = !v0 || adv1;
  assign load1    = v0 && adv1;
  assign load2    = v1 && adv2;
  assign in_stall = !adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv0) begin
        v0 <= in_valid;
      end
      if (adv1) begin
        v1 <= v0;
      end
      if (adv2) begin
        out_valid <= v1;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_valid && adv0) begin
      sample_q <= sample;
    end
  end

  bwlp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  bwlp_feedback #(
    .COEF_FRAC_BITS  (COEF_FRAC_BITS),
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_feedback (
    .clk   (clk),
    .rst   (rst),
    .load  (load1),
    .x     (sample_q),
    .coefs (coefs),
    .mid   (mid)
  );

  bwlp_round #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_round (
    .clk      (clk),
    .load     (load2),
    .mid      (mid),
    .filtered (filtered)
  );

endmodule

### hw/rtl/bwlp_checker.sv
// port-level checks for the lowpass iir block, attached by bind
// depends on bwlp_pkg and butterworth_lowpass_iir4
module bwlp_checker
  import bwlp_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] filtered,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered))
    else $error("stalled result changed");

  // input side only stalls when the output side does
  a_no_false_stall: assert property (@(posedge clk)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled while output is free");

  // an accepted item reaches the output when the output side does not stall meanwhile
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted item did not come out");

  // configuration writes are never held off
  a_cfg_ready: assert property (@(posedge clk) cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

endmodule

bind butterworth_lowpass_iir4 bwlp_checker u_bwlp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .filtered  (filtered),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
